### hdl/nfpa_pkg.sv
// nfpa_pkg: field widths and request codes shared by the next-fit pool allocator
// and its port checker. No dependencies.
package nfpa_pkg;

   localparam int MODE_W   = 1;
   localparam int SIZE_W   = 20;
   localparam int OFFS_W   = 20;
   localparam int LEN_W    = 21;
   localparam int USE_W    = 21;
   localparam int REM_W    = 22;

   // internal byte arithmetic, wide enough for any pool length and header
   localparam int BYTE_W   = 23;
   localparam int CMP_W    = 25;

   localparam logic MODE_ALLOC   = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   typedef logic [BYTE_W-1:0] byte_count_type;

endpackage

### hdl/next_fit_pool_allocator.sv
// next_fit_pool_allocator: next-fit allocator over a byte pool with a linked block table.
// Depends on nfpa_pkg.
//
//  channel | ports                                   | direction
//  req     | req_valid req_stall req_mode ...        | in, one request at a time
//  rsp     | rsp_valid rsp_stall rsp_ok ...          | out, one result per request
//  csr     | csr_write_enable csr_write_data         | in, pool length, clears the pool
//
// an allocate does a free-entry scan at one entry a cycle, then up to two list walks that
// read, check and step one block at a time over the single-port table memories.
// a release reads and compares each table entry in turn.
// reset and a csr write clear the valid bits at once, no clearing pass.
// req_stall stays high while a request is in flight or a result waits on rsp_stall.
module next_fit_pool_allocator #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 16,
   parameter int ADDR_BITS    = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [nfpa_pkg::MODE_W-1:0]   req_mode,
   input  logic [nfpa_pkg::SIZE_W-1:0]   req_request_size,
   input  logic [nfpa_pkg::OFFS_W-1:0]   req_release_offset,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_ok,
   output logic [nfpa_pkg::OFFS_W-1:0]   rsp_data_offset,
   output logic [nfpa_pkg::USE_W-1:0]    rsp_bytes_in_use,
   output logic [nfpa_pkg::USE_W-1:0]    rsp_peak_in_use,
   output logic signed [nfpa_pkg::REM_W-1:0] rsp_bytes_remaining,
   input  logic                          csr_write_enable,
   input  logic [nfpa_pkg::LEN_W-1:0]    csr_write_data
);
   import nfpa_pkg::*;

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_BLOCKS - 1);
   localparam logic [IW:0] STEP_MAX = (IW + 1)'(MAX_BLOCKS);
   localparam byte_count_type HB = BYTE_W'(HEADER_BYTES);
   localparam longint CAP = 64'd1 << ADDR_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_FREE, S_RD, S_CUR, S_NX, S_LINK1, S_LINK2, S_RRD, S_REV, S_RDO, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [REM_W-1:0] pool_ff, pool_in;
   logic [MAX_BLOCKS-1:0] live_ff, live_in, nok_ff, nok_in, pok_ff, pok_in;
   logic [IW-1:0] last_ff, last_in, idx_ff, idx_in, slot_ff, slot_in;
   logic [IW-1:0] cur_ff, cur_in, nx_ff, nx_in;
   logic [IW:0] steps_ff, steps_in;
   logic pass_ff, pass_in, anok_ff, anok_in;
   byte_count_type in_use_ff, in_use_in, peak_ff, peak_in, end_ff, end_in;
   logic [LEN_W-1:0] need_ff, need_in;
   logic [OFFS_W-1:0] off_ff, off_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_ok_ff, rsp_ok_in;
   logic [OFFS_W-1:0] rsp_data_ff, rsp_data_in;
   logic [USE_W-1:0] rsp_use_ff, rsp_use_in, rsp_peak_ff, rsp_peak_in;
   logic [REM_W-1:0] rsp_rem_ff, rsp_rem_in;

   // table memories, single port each
   logic [REM_W-1:0] start_mem [MAX_BLOCKS];
   logic [LEN_W-1:0] size_mem [MAX_BLOCKS];
   logic [IW-1:0] next_mem [MAX_BLOCKS];
   logic [IW-1:0] prev_mem [MAX_BLOCKS];
   logic [REM_W-1:0] start_rd_ff;
   logic [LEN_W-1:0] size_rd_ff;
   logic [IW-1:0] next_rd_ff, prev_rd_ff;
   logic rdz_ff;

   logic rd_en;
   logic [IW-1:0] rd_addr;
   logic geo_we, next_we, prev_we;
   logic [IW-1:0] geo_waddr, next_waddr, prev_waddr;
   logic [IW-1:0] next_wdata, prev_wdata;

   byte_count_type start_q, size_q, end_cur, room_end, req_need;
   logic signed [CMP_W-1:0] room, gap;
   logic fit_tail, fit_gap, accept;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         start_rd_ff <= start_mem[rd_addr];
         size_rd_ff  <= size_mem[rd_addr];
         next_rd_ff  <= next_mem[rd_addr];
         prev_rd_ff  <= prev_mem[rd_addr];
         rdz_ff      <= (rd_addr == '0);
      end
      if (geo_we) begin
         start_mem[geo_waddr] <= REM_W'(end_ff);
         size_mem[geo_waddr]  <= need_ff;
      end
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
   end

   // sentinel reads as offset zero, size zero
   assign start_q  = rdz_ff ? '0 : BYTE_W'(start_rd_ff);
   assign size_q   = rdz_ff ? '0 : BYTE_W'(size_rd_ff);
   assign end_cur  = start_q + HB + size_q;
   assign room_end = end_cur + HB;
   assign room     = $signed(CMP_W'(pool_ff)) - $signed(CMP_W'(room_end));
   assign fit_tail = (room > 0) && ($signed(CMP_W'(need_ff)) <= room);
   assign gap      = $signed(CMP_W'(start_q)) - $signed(CMP_W'(end_ff));
   assign fit_gap  = $signed(CMP_W'(BYTE_W'(need_ff) + HB)) <= gap;
   assign req_need = (BYTE_W'(req_request_size) + BYTE_W'(3)) & ~BYTE_W'(3);
   assign accept   = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      pool_in = pool_ff;
      live_in = live_ff;
      nok_in = nok_ff;
      pok_in = pok_ff;
      last_in = last_ff;
      idx_in = idx_ff;
      slot_in = slot_ff;
      cur_in = cur_ff;
      nx_in = nx_ff;
      steps_in = steps_ff;
      pass_in = pass_ff;
      anok_in = anok_ff;
      in_use_in = in_use_ff;
      peak_in = peak_ff;
      end_in = end_ff;
      need_in = need_ff;
      off_in = off_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ok_in = rsp_ok_ff;
      rsp_data_in = rsp_data_ff;
      rsp_use_in = rsp_use_ff;
      rsp_peak_in = rsp_peak_ff;
      rsp_rem_in = rsp_rem_ff;
      rd_en = 1'b0;
      rd_addr = cur_ff;
      geo_we = 1'b0;
      next_we = 1'b0;
      prev_we = 1'b0;
      geo_waddr = slot_ff;
      next_waddr = slot_ff;
      prev_waddr = slot_ff;
      next_wdata = nx_ff;
      prev_wdata = cur_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               need_in = LEN_W'(req_need);
               off_in = req_release_offset;
               idx_in = IW'(1);
               rsp_ok_in = 1'b0;
               rsp_data_in = '0;
               if (pool_ff == '0) begin
                  state_in = S_DONE;
               end else if (req_mode == MODE_ALLOC) begin
                  state_in = S_FREE;
               end else begin
                  state_in = S_RRD;
               end
            end
         end
         S_FREE: begin
            if (!live_ff[idx_ff]) begin
               slot_in = idx_ff;
               cur_in = last_ff;
               steps_in = '0;
               pass_in = 1'b0;
               state_in = S_RD;
            end else if (idx_ff == LAST_IDX) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_RD: begin
            rd_en = 1'b1;
            rd_addr = cur_ff;
            state_in = S_CUR;
         end
         S_CUR: begin
            end_in = end_cur;
            if (!nok_ff[cur_ff]) begin
               anok_in = 1'b0;
               if (fit_tail) begin
                  state_in = S_LINK1;
               end else if (!pass_ff) begin
                  pass_in = 1'b1;
                  cur_in = '0;
                  steps_in = '0;
                  state_in = S_RD;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               nx_in = next_rd_ff;
               rd_en = 1'b1;
               rd_addr = next_rd_ff;
               state_in = S_NX;
            end
         end
         S_NX: begin
            if (fit_gap) begin
               anok_in = 1'b1;
               state_in = S_LINK1;
            end else if (steps_ff + (IW + 1)'(1) == STEP_MAX) begin
               if (!pass_ff) begin
                  pass_in = 1'b1;
                  cur_in = '0;
                  steps_in = '0;
                  state_in = S_RD;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               cur_in = nx_ff;
               steps_in = steps_ff + (IW + 1)'(1);
               state_in = S_RD;
            end
         end
         S_LINK1: begin
            geo_we = 1'b1;
            next_we = 1'b1;
            prev_we = 1'b1;
            live_in[slot_ff] = 1'b1;
            nok_in[slot_ff] = anok_ff;
            pok_in[slot_ff] = 1'b1;
            state_in = S_LINK2;
         end
         S_LINK2: begin
            next_we = 1'b1;
            next_waddr = cur_ff;
            next_wdata = slot_ff;
            nok_in[cur_ff] = 1'b1;
            if (anok_ff) begin
               prev_we = 1'b1;
               prev_waddr = nx_ff;
               prev_wdata = slot_ff;
               pok_in[nx_ff] = 1'b1;
            end
            last_in = cur_ff;
            in_use_in = in_use_ff + BYTE_W'(need_ff) + HB;
            if (in_use_in > peak_ff) begin
               peak_in = in_use_in;
            end
            rsp_ok_in = 1'b1;
            rsp_data_in = OFFS_W'(end_ff + HB);
            state_in = S_DONE;
         end
         S_RRD: begin
            rd_en = 1'b1;
            rd_addr = idx_ff;
            state_in = S_REV;
         end
         S_REV: begin
            if (live_ff[idx_ff] && (start_q + HB == BYTE_W'(off_ff))) begin
               slot_in = idx_ff;
               state_in = S_RDO;
            end else if (idx_ff == LAST_IDX) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + IW'(1);
               state_in = S_RRD;
            end
         end
         S_RDO: begin
            if (nok_ff[slot_ff] && pok_ff[slot_ff]) begin
               next_we = 1'b1;
               next_waddr = prev_rd_ff;
               next_wdata = next_rd_ff;
               nok_in[prev_rd_ff] = 1'b1;
               prev_we = 1'b1;
               prev_waddr = next_rd_ff;
               prev_wdata = prev_rd_ff;
               pok_in[next_rd_ff] = 1'b1;
               if (last_ff == slot_ff) begin
                  last_in = prev_rd_ff;
               end
            end else begin
               if (pok_ff[slot_ff]) begin
                  nok_in[prev_rd_ff] = 1'b0;
               end
               if (last_ff == slot_ff) begin
                  last_in = '0;
               end
            end
            live_in[slot_ff] = 1'b0;
            nok_in[slot_ff] = 1'b0;
            pok_in[slot_ff] = 1'b0;
            in_use_in = in_use_ff - BYTE_W'(size_rd_ff) - HB;
            rsp_ok_in = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_use_in = USE_W'(in_use_ff);
            rsp_peak_in = USE_W'(peak_ff);
            rsp_rem_in = REM_W'(BYTE_W'(pool_ff) - in_use_ff);
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // pool length write clears the table
      if (csr_write_enable) begin
         pool_in = (64'(csr_write_data) > CAP) ? REM_W'(CAP) : REM_W'(csr_write_data);
         live_in = MAX_BLOCKS'(1);
         nok_in = '0;
         pok_in = '0;
         last_in = '0;
         in_use_in = '0;
         peak_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pool_ff <= '0;
         live_ff <= MAX_BLOCKS'(1);
         nok_ff <= '0;
         pok_ff <= '0;
         last_ff <= '0;
         in_use_ff <= '0;
         peak_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pool_ff <= pool_in;
         live_ff <= live_in;
         nok_ff <= nok_in;
         pok_ff <= pok_in;
         last_ff <= last_in;
         in_use_ff <= in_use_in;
         peak_ff <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      slot_ff <= slot_in;
      cur_ff <= cur_in;
      nx_ff <= nx_in;
      steps_ff <= steps_in;
      pass_ff <= pass_in;
      anok_ff <= anok_in;
      end_ff <= end_in;
      need_ff <= need_in;
      off_ff <= off_in;
      rsp_ok_ff <= rsp_ok_in;
      rsp_data_ff <= rsp_data_in;
      rsp_use_ff <= rsp_use_in;
      rsp_peak_ff <= rsp_peak_in;
      rsp_rem_ff <= rsp_rem_in;
   end

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok = rsp_ok_ff;
   assign rsp_data_offset = rsp_data_ff;
   assign rsp_bytes_in_use = rsp_use_ff;
   assign rsp_peak_in_use = rsp_peak_ff;
   assign rsp_bytes_remaining = $signed(rsp_rem_ff);

endmodule

### hdl/nfpa_checker.sv
// nfpa_checker: port-level checks on the next-fit pool allocator, bound to every allocator instance.
// Depends on nfpa_pkg and next_fit_pool_allocator.
module nfpa_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_ok,
   input logic [nfpa_pkg::OFFS_W-1:0] rsp_data_offset,
   input logic [nfpa_pkg::USE_W-1:0]  rsp_bytes_in_use,
   input logic [nfpa_pkg::USE_W-1:0]  rsp_peak_in_use
);
   import nfpa_pkg::*;

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped while stalled");

   // no new request taken while a result waits
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken with result pending");

   // a request accepted is followed by a busy cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("not busy after request");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_data_offset == '0) else $error("offset on failure");

   a_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_peak_in_use >= rsp_bytes_in_use) else $error("peak below use");

endmodule

bind next_fit_pool_allocator nfpa_checker u_nfpa_checker (.*);

### dv/tb_top.sv
// tb_top: self-checking testbench for next_fit_pool_allocator, with an inline next-fit
// predictor, directed and random request streams, random stalls and a watchdog.
// Depends on nfpa_pkg and next_fit_pool_allocator.
module tb_top;
   import nfpa_pkg::*;

   localparam int NBLK  = 64;
   localparam int HDR   = 16;
   localparam longint POOL_CAP = 64'd1 << 20;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic                ok;
      logic [OFFS_W-1:0]   data_offset;
      logic [USE_W-1:0]    in_use;
      logic [USE_W-1:0]    peak;
      logic [REM_W-1:0]    remaining;
   } pool_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [MODE_W-1:0]    req_mode = MODE_ALLOC;
   logic [SIZE_W-1:0]    req_request_size = '0;
   logic [OFFS_W-1:0]    req_release_offset = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_ok;
   logic [OFFS_W-1:0]    rsp_data_offset;
   logic [USE_W-1:0]     rsp_bytes_in_use;
   logic [USE_W-1:0]     rsp_peak_in_use;
   logic signed [REM_W-1:0] rsp_bytes_remaining;
   logic                 csr_write_enable = 1'b0;
   logic [LEN_W-1:0]     csr_write_data = '0;

   // allocator shadow state
   longint       pool_len;
   longint       used_bytes;
   longint       peak_bytes;
   int           cursor;
   longint       blk_start [NBLK];
   longint       blk_size  [NBLK];
   int           blk_next  [NBLK];
   int           blk_prev  [NBLK];
   bit           has_next  [NBLK];
   bit           has_prev  [NBLK];
   bit           live      [NBLK];

   pool_result_type pending_results [$];
   logic [OFFS_W-1:0] live_offsets [$];
   int           errors = 0;
   bit           quiet = 1'b0;
   bit           hold_request = 1'b0;
   int           hold_left = 0;
   int           idle_cycles = 0;

   next_fit_pool_allocator u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_request_size    (req_request_size),
      .req_release_offset  (req_release_offset),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_ok              (rsp_ok),
      .rsp_data_offset     (rsp_data_offset),
      .rsp_bytes_in_use    (rsp_bytes_in_use),
      .rsp_peak_in_use     (rsp_peak_in_use),
      .rsp_bytes_remaining (rsp_bytes_remaining),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void clear_pool();
      for (int i = 0; i < NBLK; i++) begin
         blk_start[i] = 0;
         blk_size[i]  = 0;
         blk_next[i]  = 0;
         blk_prev[i]  = 0;
         has_next[i]  = 1'b0;
         has_prev[i]  = 1'b0;
         live[i]      = 1'b0;
      end
      live[0]    = 1'b1;
      cursor     = 0;
      used_bytes = 0;
      peak_bytes = 0;
   endfunction

   function automatic int find_gap(longint need, int seed);
      int     cur;
      longint end_pos;
      longint room;
      cur = seed;
      for (int steps = 0; steps < NBLK; steps++) begin
         end_pos = blk_start[cur] + HDR + blk_size[cur];
         if (!has_next[cur]) begin
            room = pool_len - (end_pos + HDR);
            if (room > 0 && need <= room) return cur;
            return -1;
         end
         if (need + HDR <= blk_start[blk_next[cur]] - end_pos) return cur;
         cur = blk_next[cur];
      end
      return -1;
   endfunction

   function automatic pool_result_type predict_request(logic mode, longint size, longint offs);
      pool_result_type r;
      longint       need;
      int           slot;
      int           after;
      int           hit;
      int           pv;
      int           nx;
      r.ok = 1'b0;
      r.data_offset = '0;
      slot = 0;
      hit  = 0;
      if (pool_len != 0 && mode == MODE_ALLOC) begin
         need = (size + 3) & ~64'd3;
         for (int i = 1; i < NBLK; i++)
            if (!live[i] && slot == 0) slot = i;
         after = -1;
         if (slot != 0) begin
            after = find_gap(need, cursor);
            if (after < 0) after = find_gap(need, 0);
         end
         if (after >= 0) begin
            cursor = after;
            blk_start[slot] = blk_start[after] + HDR + blk_size[after];
            blk_size[slot]  = need;
            live[slot]      = 1'b1;
            blk_next[slot]  = blk_next[after];
            has_next[slot]  = has_next[after];
            blk_prev[slot]  = after;
            has_prev[slot]  = 1'b1;
            if (has_next[after]) begin
               blk_prev[blk_next[after]] = slot;
               has_prev[blk_next[after]] = 1'b1;
            end
            blk_next[after] = slot;
            has_next[after] = 1'b1;
            used_bytes += need + HDR;
            if (used_bytes > peak_bytes) peak_bytes = used_bytes;
            r.ok = 1'b1;
            r.data_offset = OFFS_W'(blk_start[slot] + HDR);
         end
      end else if (pool_len != 0) begin
         for (int i = 1; i < NBLK; i++)
            if (hit == 0 && live[i] && blk_start[i] + HDR == offs) hit = i;
         if (hit != 0) begin
            pv = blk_prev[hit];
            nx = blk_next[hit];
            if (has_next[hit] && has_prev[hit]) begin
               blk_next[pv] = nx;
               has_next[pv] = 1'b1;
               blk_prev[nx] = pv;
               has_prev[nx] = 1'b1;
               if (cursor == hit) cursor = pv;
            end else begin
               if (has_prev[hit]) begin
                  blk_next[pv] = 0;
                  has_next[pv] = 1'b0;
               end
               if (cursor == hit) cursor = 0;
            end
            used_bytes -= blk_size[hit] + HDR;
            blk_start[hit] = 0;
            blk_size[hit]  = 0;
            blk_next[hit]  = 0;
            blk_prev[hit]  = 0;
            has_next[hit]  = 1'b0;
            has_prev[hit]  = 1'b0;
            live[hit]      = 1'b0;
            r.ok = 1'b1;
         end
      end
      r.in_use    = used_bytes[USE_W-1:0];
      r.peak      = peak_bytes[USE_W-1:0];
      r.remaining = REM_W'(pool_len - used_bytes);
      return r;
   endfunction

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = 400;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = !quiet && ($urandom_range(99) < 12);
      end
   end

   always @(posedge clock) begin
      pool_result_type exp_r;
      if (rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result with no request outstanding");
            errors++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_ok !== exp_r.ok) begin
               $error("ok: expected %0d, actual %0d", exp_r.ok, rsp_ok);
               errors++;
            end
            if (rsp_data_offset !== exp_r.data_offset) begin
               $error("data_offset: expected %0d, actual %0d",
                      exp_r.data_offset, rsp_data_offset);
               errors++;
            end
            if (rsp_bytes_in_use !== exp_r.in_use) begin
               $error("bytes_in_use: expected %0d, actual %0d",
                      exp_r.in_use, rsp_bytes_in_use);
               errors++;
            end
            if (rsp_peak_in_use !== exp_r.peak) begin
               $error("peak_in_use: expected %0d, actual %0d",
                      exp_r.peak, rsp_peak_in_use);
               errors++;
            end
            if (rsp_bytes_remaining !== exp_r.remaining) begin
               $error("bytes_remaining: expected %0d, actual %0d",
                      $signed(exp_r.remaining), rsp_bytes_remaining);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_request(logic mode, logic [SIZE_W-1:0] size,
                               logic [OFFS_W-1:0] offs);
      pool_result_type r;
      if (!quiet && $urandom_range(99) < 12) begin
         repeat ($urandom_range(1, 5)) begin
            @(negedge clock);
            req_valid = 1'b0;
         end
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_mode = mode;
      req_request_size = size;
      req_release_offset = offs;
      do @(posedge clock); while (req_stall);
      r = predict_request(mode, longint'(size), longint'(offs));
      pending_results.push_back(r);
      if (mode == MODE_ALLOC && r.ok) live_offsets.push_back(r.data_offset);
   endtask

   task automatic release_live(int pick);
      logic [OFFS_W-1:0] o;
      o = live_offsets[pick];
      live_offsets.delete(pick);
      send_request(MODE_RELEASE, '0, o);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_pool_length(logic [LEN_W-1:0] len);
      drain();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = len;
      @(negedge clock);
      csr_write_enable = 1'b0;
      csr_write_data = LEN_W'($urandom());
      pool_len = (len > POOL_CAP) ? POOL_CAP : len;
      clear_pool();
      live_offsets.delete();
   endtask

   task automatic test_uninitialised();
      send_request(MODE_ALLOC, 20'd4, '0);
      send_request(MODE_RELEASE, '0, 20'd16);
      send_request(MODE_ALLOC, '1, '1);
   endtask

   task automatic test_directed();
      write_pool_length('1);
      send_request(MODE_ALLOC, 20'd0, '0);
      send_request(MODE_ALLOC, 20'd1, '0);
      send_request(MODE_ALLOC, 20'd5, '0);
      send_request(MODE_ALLOC, '1, '0);
      send_request(MODE_RELEASE, '0, '0);
      send_request(MODE_RELEASE, '0, '1);
      send_request(MODE_RELEASE, '0, 20'd17);
      release_live(1);
      send_request(MODE_ALLOC, 20'd2, '0);
      release_live(live_offsets.size() - 1);
      release_live(0);
      send_request(MODE_ALLOC, 20'd1000, '0);
      write_pool_length(21'd64);
      send_request(MODE_ALLOC, 20'd16, '0);
      send_request(MODE_ALLOC, 20'd4, '0);
      release_live(0);
      send_request(MODE_RELEASE, '0, 20'd16);
      write_pool_length(21'h100000);
      send_request(MODE_ALLOC, 20'd1048540, '0);
      send_request(MODE_ALLOC, 20'd1048544, '0);
   endtask

   task automatic test_table_full();
      write_pool_length(21'd4096);
      repeat (66) send_request(MODE_ALLOC, 20'($urandom_range(0, 8)), '0);
      release_live(10);
      release_live(30);
      send_request(MODE_ALLOC, 20'd0, '0);
      send_request(MODE_ALLOC, 20'd0, '0);
      send_request(MODE_ALLOC, 20'd0, '0);
   endtask

   task automatic test_backpressure();
      write_pool_length(21'd8192);
      @(posedge clock);
      hold_request = 1'b1;
      repeat (20) send_request(MODE_ALLOC, 20'($urandom_range(0, 100)), '0);
      drain();
      repeat (10) release_live($urandom_range(0, live_offsets.size() - 1));
   endtask

   task automatic random_mix(int count, int max_size);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 55) begin
            send_request(MODE_ALLOC, 20'($urandom_range(0, max_size)), 20'($urandom()));
         end else if (r < 60) begin
            send_request(MODE_ALLOC, 20'($urandom()), 20'($urandom()));
         end else if (r < 88 && live_offsets.size() != 0) begin
            release_live($urandom_range(0, live_offsets.size() - 1));
         end else if (r < 94 && live_offsets.size() != 0) begin
            send_request(MODE_RELEASE, 20'($urandom()),
                         OFFS_W'(live_offsets[$urandom_range(0, live_offsets.size() - 1)] + 4));
         end else begin
            send_request(MODE_RELEASE, 20'($urandom()), 20'($urandom()));
         end
      end
   endtask

   task automatic test_random();
      write_pool_length(21'($urandom_range(200, 4096)));
      random_mix(250, 120);
      write_pool_length(21'h100000);
      random_mix(250, 4000);
      quiet = 1'b1;
      write_pool_length(21'($urandom_range(1, 2048)));
      random_mix(150, 64);
      quiet = 1'b0;
      write_pool_length(21'($urandom()));
      random_mix(200, 30000);
   endtask

   initial begin
      pool_len = 0;
      clear_pool();
      repeat (6) @(negedge clock);
      reset = 1'b0;
      test_uninitialised();
      test_directed();
      test_table_full();
      test_backpressure();
      test_random();
      drain();
      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
